/* src/sum_checked_frame_receiver_top_assert.svh */
// ============================================================================
// Assertion macros for the frame receiver checker
// Shared property forms, clocked and disabled during reset.
// ============================================================================
`ifndef SUM_CHECKED_FRAME_RECEIVER_TOP_ASSERT_SVH
`define SUM_CHECKED_FRAME_RECEIVER_TOP_ASSERT_SVH

// Same-cycle implication
`define SCFR_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define SCFR_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/scfr_pkg.sv */
// ============================================================================
// scfr_pkg
// Types and constants shared by the frame receiver modules.
// ============================================================================
package scfr_pkg;

    // Field widths
    localparam int BYTE_W      = 8;
    localparam int LEN_W       = 6;
    localparam int STATUS_W    = 2;
    localparam int CFG_INDEX_W = 3;
    localparam int OUT_DATA_W  = 40;

    // Result status codes
    localparam logic [STATUS_W-1:0] STATUS_DATA  = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_ERROR = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_SYNC_FIRST  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SYNC_SECOND = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_FUNC_LIMIT  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_PAYLOAD = 3'd3;

    // Configuration reset values
    localparam logic [BYTE_W-1:0] RST_SYNC_FIRST  = 8'hAA;
    localparam logic [BYTE_W-1:0] RST_SYNC_SECOND = 8'hAF;
    localparam logic [BYTE_W-1:0] RST_FUNC_LIMIT  = 8'hF1;
    localparam logic [LEN_W-1:0]  RST_MAX_PAYLOAD = 6'd49;

    // Controller states, one-hot
    typedef enum logic [7:0] {
        ST_SYNC1   = 8'b0000_0001,
        ST_SYNC2   = 8'b0000_0010,
        ST_FUNC    = 8'b0000_0100,
        ST_LEN     = 8'b0000_1000,
        ST_PAYLOAD = 8'b0001_0000,
        ST_CHECK   = 8'b0010_0000,
        ST_READ    = 8'b0100_0000,
        ST_EMIT    = 8'b1000_0000
    } scfr_state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic in_ready;
        logic sum_load;
        logic sum_add;
        logic func_load;
        logic len_load;
        logic store_write;
        logic emit_start;
        logic emit_next;
        logic rd_en;
        logic out_load_data;
        logic out_load_error;
        logic out_load_empty;
    } scfr_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic sync1_hit;
        logic sync2_hit;
        logic func_ok;
        logic len_ok;
        logic len_in_zero;
        logic seen_last;
        logic sum_ok;
        logic frame_empty;
        logic out_taken;
        logic out_last;
    } scfr_status_t;

endpackage

/* src/scfr_ram.sv */
// ============================================================================
// scfr_ram
// Simple dual-port RAM, one write and one registered read port.
// ============================================================================
module scfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* src/scfr_ctrl.sv */
// ============================================================================
// scfr_ctrl
// Frame parser state machine: header hunt, payload fill, check and emit.
// ============================================================================
module scfr_ctrl (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_tvalid,
    input  scfr_pkg::scfr_status_t  stat,
    output scfr_pkg::scfr_cmd_t     cmd
);

    import scfr_pkg::*;

    scfr_state_t state_reg, state_next;
    logic        accept;

    // Input transfer: every state outside the emit loop takes bytes
    assign accept = s_tvalid && (state_reg != ST_READ) && (state_reg != ST_EMIT);

    // Hold state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_SYNC1;
        end else begin
            state_reg <= state_next;
        end
    end

    // Decode next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_SYNC1: begin
                cmd.in_ready = 1'b1;
                if (accept && stat.sync1_hit) begin
                    cmd.sum_load = 1'b1;
                    state_next   = ST_SYNC2;
                end
            end
            ST_SYNC2: begin
                cmd.in_ready = 1'b1;
                if (accept) begin
                    if (stat.sync2_hit) begin
                        cmd.sum_add = 1'b1;
                        state_next  = ST_FUNC;
                    end else begin
                        state_next  = ST_SYNC1;
                    end
                end
            end
            ST_FUNC: begin
                cmd.in_ready = 1'b1;
                if (accept) begin
                    if (stat.func_ok) begin
                        cmd.sum_add   = 1'b1;
                        cmd.func_load = 1'b1;
                        state_next    = ST_LEN;
                    end else begin
                        state_next    = ST_SYNC1;
                    end
                end
            end
            ST_LEN: begin
                cmd.in_ready = 1'b1;
                if (accept) begin
                    if (stat.len_ok) begin
                        cmd.sum_add  = 1'b1;
                        cmd.len_load = 1'b1;
                        state_next   = stat.len_in_zero ? ST_CHECK : ST_PAYLOAD;
                    end else begin
                        state_next   = ST_SYNC1;
                    end
                end
            end
            ST_PAYLOAD: begin
                cmd.in_ready = 1'b1;
                if (accept) begin
                    cmd.sum_add     = 1'b1;
                    cmd.store_write = 1'b1;
                    if (stat.seen_last) begin
                        state_next = ST_CHECK;
                    end
                end
            end
            ST_CHECK: begin
                cmd.in_ready = 1'b1;
                if (accept) begin
                    if (!stat.sum_ok) begin
                        cmd.out_load_error = 1'b1;
                        state_next         = ST_EMIT;
                    end else if (stat.frame_empty) begin
                        cmd.out_load_empty = 1'b1;
                        state_next         = ST_EMIT;
                    end else begin
                        cmd.emit_start = 1'b1;
                        cmd.rd_en      = 1'b1;
                        state_next     = ST_READ;
                    end
                end
            end
            ST_READ: begin
                // read data is back, move it to the output register
                cmd.out_load_data = 1'b1;
                state_next        = ST_EMIT;
            end
            ST_EMIT: begin
                if (stat.out_taken) begin
                    if (stat.out_last) begin
                        state_next = ST_SYNC1;
                    end else begin
                        cmd.emit_next = 1'b1;
                        cmd.rd_en     = 1'b1;
                        state_next    = ST_READ;
                    end
                end
            end
            default: begin
                state_next = ST_SYNC1;
            end
        endcase
    end

endmodule

/* src/scfr_dp.sv */
// ============================================================================
// scfr_dp
// Datapath: configuration registers, header fields, running sum,
// payload buffer and the result register.
// ============================================================================
module scfr_dp #(
    parameter int PAYLOAD_DEPTH = 64
) (
    input  logic                                     aclk,
    input  logic                                     aresetn,
    input  scfr_pkg::scfr_cmd_t                      cmd,
    output scfr_pkg::scfr_status_t                   stat,
    input  logic [scfr_pkg::BYTE_W-1:0]              rx_byte,
    input  logic                                     cfg_valid,
    input  logic [scfr_pkg::CFG_INDEX_W-1:0]         cfg_index,
    input  logic [scfr_pkg::BYTE_W-1:0]              cfg_data,
    output logic                                     m_tvalid,
    input  logic                                     m_tready,
    output logic [scfr_pkg::OUT_DATA_W-1:0]          m_tdata,
    output logic [scfr_pkg::STATUS_W-1:0]            m_tuser,
    output logic                                     m_tlast
);

    import scfr_pkg::*;

    localparam int ADDR_W = $clog2(PAYLOAD_DEPTH);

    logic [BYTE_W-1:0]   sync_first_reg;
    logic [BYTE_W-1:0]   sync_second_reg;
    logic [BYTE_W-1:0]   func_limit_reg;
    logic [LEN_W-1:0]    max_payload_reg;

    logic [BYTE_W-1:0]   func_reg;
    logic [LEN_W-1:0]    len_reg;
    logic [LEN_W-1:0]    seen_reg;
    logic [BYTE_W-1:0]   sum_reg;
    logic [LEN_W-1:0]    emit_idx_reg;

    logic                out_valid_reg;
    logic [STATUS_W-1:0] out_status_reg;
    logic [BYTE_W-1:0]   out_func_reg;
    logic [LEN_W-1:0]    out_len_reg;
    logic [LEN_W-1:0]    out_idx_reg;
    logic [BYTE_W-1:0]   out_byte_reg;
    logic [BYTE_W-1:0]   out_sum_reg;
    logic                out_last_reg;

    logic [BYTE_W-1:0]   ram_rdata;
    logic                emit_last;

    // Configuration writes; unknown indexes are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sync_first_reg  <= RST_SYNC_FIRST;
            sync_second_reg <= RST_SYNC_SECOND;
            func_limit_reg  <= RST_FUNC_LIMIT;
            max_payload_reg <= RST_MAX_PAYLOAD;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_SYNC_FIRST:  sync_first_reg  <= cfg_data;
                REG_SYNC_SECOND: sync_second_reg <= cfg_data;
                REG_FUNC_LIMIT:  func_limit_reg  <= cfg_data;
                REG_MAX_PAYLOAD: max_payload_reg <= cfg_data[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    // Header fields, fill count and running sum
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            func_reg     <= '0;
            len_reg      <= '0;
            seen_reg     <= '0;
            sum_reg      <= '0;
            emit_idx_reg <= '0;
        end else begin
            if (cmd.sum_load) begin
                sum_reg <= rx_byte;
            end else if (cmd.sum_add) begin
                sum_reg <= sum_reg + rx_byte;
            end
            if (cmd.func_load) begin
                func_reg <= rx_byte;
            end
            if (cmd.len_load) begin
                len_reg  <= rx_byte[LEN_W-1:0];
                seen_reg <= '0;
            end else if (cmd.store_write) begin
                seen_reg <= seen_reg + LEN_W'(1);
            end
            if (cmd.emit_start) begin
                emit_idx_reg <= '0;
            end else if (cmd.emit_next) begin
                emit_idx_reg <= emit_idx_reg + LEN_W'(1);
            end
        end
    end

    // Payload buffer
    scfr_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (PAYLOAD_DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (cmd.store_write),
        .waddr (ADDR_W'(seen_reg)),
        .wdata (rx_byte),
        .re    (cmd.rd_en),
        .raddr (cmd.emit_start ? '0 : ADDR_W'(emit_idx_reg + LEN_W'(1))),
        .rdata (ram_rdata)
    );

    assign emit_last = (emit_idx_reg + LEN_W'(1)) == len_reg;

    // Result register: load from the buffer or a one-shot status, drop on transfer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.out_load_data || cmd.out_load_error || cmd.out_load_empty) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load_data) begin
            out_status_reg <= STATUS_DATA;
            out_idx_reg    <= emit_idx_reg;
            out_byte_reg   <= ram_rdata;
            out_last_reg   <= emit_last;
        end else if (cmd.out_load_error || cmd.out_load_empty) begin
            out_status_reg <= cmd.out_load_error ? STATUS_ERROR : STATUS_EMPTY;
            out_idx_reg    <= '0;
            out_byte_reg   <= '0;
            out_last_reg   <= 1'b1;
        end
        if (cmd.out_load_data || cmd.out_load_error || cmd.out_load_empty) begin
            out_func_reg <= func_reg;
            out_len_reg  <= len_reg;
            out_sum_reg  <= sum_reg;
        end
    end

    // Status toward the controller
    always_comb begin
        stat.sync1_hit   = rx_byte == sync_first_reg;
        stat.sync2_hit   = rx_byte == sync_second_reg;
        stat.func_ok     = rx_byte < func_limit_reg;
        stat.len_ok      = (rx_byte <= {{(BYTE_W-LEN_W){1'b0}}, max_payload_reg})
                        && ({1'b0, rx_byte} <= (BYTE_W+1)'(PAYLOAD_DEPTH));
        stat.len_in_zero = rx_byte == '0;
        stat.seen_last   = (seen_reg + LEN_W'(1)) == len_reg;
        stat.sum_ok      = rx_byte == sum_reg;
        stat.frame_empty = len_reg == '0;
        stat.out_taken   = out_valid_reg && m_tready;
        stat.out_last    = out_last_reg;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {4'b0000, out_sum_reg, out_byte_reg, out_idx_reg, out_len_reg,
                       out_func_reg};

endmodule

/* src/sum_checked_frame_receiver_top.sv */
// ============================================================================
// sum_checked_frame_receiver_top
// Serial frame receiver with sync hunt, length check, payload buffer and
// 8-bit additive checksum.
// ============================================================================
//
//  Channel   Dir  Handshake             Payload
//  s_        in   s_tvalid / s_tready   rx_byte in s_tdata
//  m_        out  m_tvalid / m_tready   frame fields in m_tdata, status in
//                                       m_tuser, end of frame in m_tlast
//  cfg_      in   cfg_valid / cfg_ready cfg_index, cfg_data
//
//  Header, payload and checksum bytes are taken while s_tready is high.
//  A good frame of N payload bytes emits N results through the registered
//  buffer read, each held by any m_tready stall; s_tready stays low until the
//  last result transfers. Error and empty-frame results skip the buffer read.
//  Reset is synchronous, active low; the buffer needs no clearing pass.
//
module sum_checked_frame_receiver_top #(
    parameter int PAYLOAD_DEPTH = 64
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // s_tdata: [7:0] rx_byte
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [scfr_pkg::BYTE_W-1:0]           s_tdata,
    // m_tdata: [7:0] func_code, [13:8] payload_len, [19:14] byte_index,
    //          [27:20] payload_byte, [35:28] frame_sum, [39:36] zero
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [scfr_pkg::OUT_DATA_W-1:0]       m_tdata,
    // m_tuser: [1:0] status
    output logic [scfr_pkg::STATUS_W-1:0]         m_tuser,
    output logic                                  m_tlast,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [scfr_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [scfr_pkg::BYTE_W-1:0]           cfg_data
);

    import scfr_pkg::*;

    scfr_cmd_t    cmd;
    scfr_status_t stat;

    // Configuration writes always land
    assign cfg_ready = 1'b1;
    assign s_tready  = cmd.in_ready;

    scfr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .stat     (stat),
        .cmd      (cmd)
    );

    scfr_dp #(
        .PAYLOAD_DEPTH (PAYLOAD_DEPTH)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .stat      (stat),
        .rx_byte   (s_tdata),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

/* src/scfr_checker.sv */
// ============================================================================
// scfr_checker
// Port-level checks on the frame receiver, bound to the top level.
// ============================================================================
`include "sum_checked_frame_receiver_top_assert.svh"

module scfr_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_tready,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [scfr_pkg::OUT_DATA_W-1:0]  m_tdata,
    input logic [scfr_pkg::STATUS_W-1:0]    m_tuser,
    input logic                             m_tlast
);

    import scfr_pkg::*;

    // Stalled result holds
    `SCFR_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "stalled result changed")

    // No byte taken while a result waits
    `SCFR_ASSERT_NOW(a_no_input_during_emit, aclk, aresetn, m_tvalid, !s_tready, "input ready while result pending")

    // Error and empty results close the frame
    `SCFR_ASSERT_NOW(a_status_last, aclk, aresetn, m_tvalid && (m_tuser != STATUS_DATA), m_tlast && (m_tdata[27:14] == 14'd0), "status result not last or carries payload")

    // Payload position stays inside the declared length
    `SCFR_ASSERT_NOW(a_index_range, aclk, aresetn, m_tvalid && (m_tuser == STATUS_DATA), (m_tdata[19:14] < m_tdata[13:8]) && (m_tlast == ((m_tdata[19:14] + 6'd1) == m_tdata[13:8])), "payload index out of range or wrong last")

endmodule

bind sum_checked_frame_receiver_top scfr_checker u_scfr_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

/* tb/sv/tb_sum_checked_frame_receiver_top.sv */
// ============================================================================
// tb_sum_checked_frame_receiver_top
// Self-checking bench for the frame receiver. A tracker class predicts the
// results of every accepted byte from its own copy of the parser state and
// register set, and checks every result transfer field by field. Directed
// frames cover the header, length and checksum corner cases and the register
// extremes; random phases then mix well-formed frames with noise and broken
// headers under random idling on both sides and one long output stall.
// ============================================================================
module tb_sum_checked_frame_receiver_top;
    timeunit 1ns;
    timeprecision 1ps;

    import scfr_pkg::*;

    localparam int STORE_DEPTH   = 64;
    localparam int SETTLE_CYCLES = 16;
    localparam int DRAIN_LIMIT   = 20000;
    localparam int PHASE_ITEMS   = 8;
    localparam int IDLE_PCT      = 18;

    // Register indexes outside the implemented set
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED_LO = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED_HI = 3'd7;

    typedef enum int {
        RX_HUNT, RX_SYNC1, RX_SYNC2, RX_CODE, RX_PAYLOAD, RX_CHECKSUM
    } rx_phase_t;

    typedef struct {
        logic [STATUS_W-1:0] status;
        logic [BYTE_W-1:0]   func;
        logic [LEN_W-1:0]    len;
        logic [LEN_W-1:0]    index;
        logic [BYTE_W-1:0]   data;
        logic [BYTE_W-1:0]   frame_sum;
        logic                last;
    } frame_result_t;

    // ------------------------------------------------------------------------
    // Frame tracker: parser copy, register copy and the results still due
    // ------------------------------------------------------------------------
    class frame_result_tracker;
        logic [BYTE_W-1:0] sync_a;
        logic [BYTE_W-1:0] sync_b;
        logic [BYTE_W-1:0] code_limit;
        logic [LEN_W-1:0]  len_max;

        rx_phase_t         phase;
        logic [BYTE_W-1:0] code;
        logic [LEN_W-1:0]  len;
        logic [LEN_W-1:0]  count;
        logic [BYTE_W-1:0] run_sum;
        logic [BYTE_W-1:0] held_payload [STORE_DEPTH];

        frame_result_t     pending_results [$];
        int                mismatches;

        function new();
            sync_a     = RST_SYNC_FIRST;
            sync_b     = RST_SYNC_SECOND;
            code_limit = RST_FUNC_LIMIT;
            len_max    = RST_MAX_PAYLOAD;
            phase      = RX_HUNT;
            code       = '0;
            len        = '0;
            count      = '0;
            run_sum    = '0;
            mismatches = 0;
            foreach (held_payload[k]) held_payload[k] = '0;
        endfunction

        function int pending();
            return pending_results.size();
        endfunction

        // Apply a register write at the moment it transfers
        function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [BYTE_W-1:0] value);
            case (idx)
                REG_SYNC_FIRST:  sync_a     = value;
                REG_SYNC_SECOND: sync_b     = value;
                REG_FUNC_LIMIT:  code_limit = value;
                REG_MAX_PAYLOAD: len_max    = value[LEN_W-1:0];
                default: ;
            endcase
        endfunction

        function void push_result(logic [STATUS_W-1:0] status, int index,
                                  logic [BYTE_W-1:0] value, logic last);
            frame_result_t r;
            r.status    = status;
            r.func      = code;
            r.len       = len;
            r.index     = index[LEN_W-1:0];
            r.data      = value;
            r.frame_sum = run_sum;
            r.last      = last;
            pending_results.push_back(r);
        endfunction

        // Advance the parser by one accepted byte and queue what it produces
        function void note_rx_byte(logic [BYTE_W-1:0] b);
            case (phase)
                RX_HUNT: begin
                    if (b == sync_a) begin
                        run_sum = b;
                        phase   = RX_SYNC1;
                    end
                end
                RX_SYNC1: begin
                    if (b == sync_b) begin
                        run_sum += b;
                        phase    = RX_SYNC2;
                    end else begin
                        phase = RX_HUNT;
                    end
                end
                RX_SYNC2: begin
                    if (b < code_limit) begin
                        code     = b;
                        run_sum += b;
                        phase    = RX_CODE;
                    end else begin
                        phase = RX_HUNT;
                    end
                end
                RX_CODE: begin
                    if (int'(b) <= int'(len_max) && int'(b) <= STORE_DEPTH) begin
                        len      = b[LEN_W-1:0];
                        count    = '0;
                        run_sum += b;
                        phase    = (len == 0) ? RX_CHECKSUM : RX_PAYLOAD;
                    end else begin
                        phase = RX_HUNT;
                    end
                end
                RX_PAYLOAD: begin
                    if (count < len && int'(count) < STORE_DEPTH) begin
                        held_payload[count] = b;
                        count    = count + 1'b1;
                        run_sum += b;
                        if (count == len) phase = RX_CHECKSUM;
                    end else begin
                        phase = RX_HUNT;
                    end
                end
                RX_CHECKSUM: begin
                    phase = RX_HUNT;
                    if (b != run_sum) begin
                        push_result(STATUS_ERROR, 0, '0, 1'b1);
                    end else if (len == 0) begin
                        push_result(STATUS_EMPTY, 0, '0, 1'b1);
                    end else begin
                        for (int k = 0; k < int'(len) && k < STORE_DEPTH; k++)
                            push_result(STATUS_DATA, k, held_payload[k], k + 1 == int'(len));
                    end
                end
                default: phase = RX_HUNT;
            endcase
        endfunction

        task report_mismatch(string msg);
            $display("%0t ns  mismatch: %s", $time, msg);
            mismatches++;
        endtask

        task compare_field(string name, logic [BYTE_W-1:0] got, logic [BYTE_W-1:0] want);
            if (got !== want)
                report_mismatch($sformatf("%s got %h, expected %h", name, got, want));
        endtask

        // Compare one result transfer with the oldest expectation
        task check_result(logic [OUT_DATA_W-1:0] tdata, logic [STATUS_W-1:0] tuser,
                          logic tlast);
            frame_result_t want;
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result tdata=%h status=%0d last=%b",
                                          tdata, tuser, tlast));
                return;
            end
            want = pending_results.pop_front();
            compare_field("status",       BYTE_W'(tuser),        BYTE_W'(want.status));
            compare_field("func_code",    tdata[7:0],            want.func);
            compare_field("payload_len",  BYTE_W'(tdata[13:8]),  BYTE_W'(want.len));
            compare_field("byte_index",   BYTE_W'(tdata[19:14]), BYTE_W'(want.index));
            compare_field("payload_byte", tdata[27:20],          want.data);
            compare_field("frame_sum",    tdata[35:28],          want.frame_sum);
            compare_field("tdata pad",    BYTE_W'(tdata[39:36]), '0);
            compare_field("last",         BYTE_W'(tlast),        BYTE_W'(want.last));
        endtask
    endclass

    // ------------------------------------------------------------------------
    // Signals and block under test
    // ------------------------------------------------------------------------
    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [BYTE_W-1:0]      s_tdata   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0]  m_tdata;
    logic [STATUS_W-1:0]    m_tuser;
    logic                   m_tlast;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [BYTE_W-1:0]      cfg_data  = '0;

    frame_result_tracker tracker = new();

    bit steady       = 1'b0;
    int hold_request = 0;
    int bytes_sent   = 0;

    sum_checked_frame_receiver_top #(
        .PAYLOAD_DEPTH(STORE_DEPTH)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 12 ns clock
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    function bit idle_now();
        return !steady && ($urandom_range(99) < IDLE_PCT);
    endfunction

    // ------------------------------------------------------------------------
    // Result side: random stalls, plus a long hold-off on request
    // ------------------------------------------------------------------------
    initial begin
        int hold_left;
        hold_left = 0;
        wait (aresetn);
        forever begin
            @(posedge aclk);
            if (hold_request > 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                m_tready <= 1'b0;
                hold_left--;
            end else begin
                m_tready <= !idle_now();
            end
        end
    end

    // Check every result transfer
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            tracker.check_result(m_tdata, m_tuser, m_tlast);
    end

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------
    task automatic send_byte(input logic [BYTE_W-1:0] value);
        while (idle_now()) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        do @(posedge aclk); while (!s_tready);
        tracker.note_rx_byte(value);
        bytes_sent++;
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [BYTE_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        tracker.write_reg(idx, value);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // Drop valid, wait for every expected result, then let the block go quiet
    task automatic settle();
        int waited;
        waited = 0;
        s_tvalid <= 1'b0;
        while (tracker.pending() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic send_header();
        send_byte(tracker.sync_a);
        send_byte(tracker.sync_b);
    endtask

    // Full frame with the checksum over both syncs, code, length and payload;
    // spoil corrupts the checksum, alternate fills the payload with 00/FF
    task automatic send_frame(input logic [BYTE_W-1:0] code, input int length,
                              input bit spoil, input bit alternate);
        logic [BYTE_W-1:0] total;
        logic [BYTE_W-1:0] value;
        total = tracker.sync_a + tracker.sync_b + code + BYTE_W'(length);
        send_header();
        send_byte(code);
        send_byte(BYTE_W'(length));
        for (int k = 0; k < length; k++) begin
            value = alternate ? (k[0] ? 8'hFF : 8'h00) : BYTE_W'($urandom);
            send_byte(value);
            total += value;
        end
        if (spoil) total += BYTE_W'($urandom_range(1, 255));
        send_byte(total);
    endtask

    // Header faults: bad second sync, code at or over the limit, length over
    // the maximum, or a frame cut short after one payload byte
    task automatic send_broken(input int kind);
        if (kind == 3 && tracker.len_max < 2) kind = 0;
        case (kind)
            0: begin
                send_byte(tracker.sync_a);
                send_byte(tracker.sync_b ^ BYTE_W'($urandom_range(1, 255)));
            end
            1: begin
                send_header();
                send_byte(BYTE_W'($urandom_range(tracker.code_limit, 255)));
            end
            2: begin
                send_header();
                send_byte(BYTE_W'($urandom_range(0, tracker.code_limit - 1)));
                send_byte(BYTE_W'($urandom_range(tracker.len_max + 1, 255)));
            end
            default: begin
                send_header();
                send_byte(BYTE_W'($urandom_range(0, tracker.code_limit - 1)));
                send_byte(BYTE_W'($urandom_range(2, tracker.len_max)));
                send_byte(BYTE_W'($urandom));
            end
        endcase
    endtask

    task automatic send_random_item();
        int roll;
        int length;
        int short_max;
        roll      = $urandom_range(99);
        short_max = (tracker.len_max < 6) ? int'(tracker.len_max) : 6;
        if (roll < 70) begin
            length = ($urandom_range(3) == 0) ? $urandom_range(0, tracker.len_max)
                                              : $urandom_range(0, short_max);
            send_frame(BYTE_W'($urandom_range(0, tracker.code_limit - 1)), length,
                       $urandom_range(9) == 0, 1'b0);
        end else if (roll < 80) begin
            send_byte(BYTE_W'($urandom));
        end else begin
            send_broken($urandom_range(3));
        end
    endtask

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin
        int start;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset registers: noise, empty frame, code just under the limit,
        // bad checksum, code at the limit, length over the maximum, and a
        // repeated first sync that sends the parser back to the hunt
        send_byte(8'h00);
        send_byte(8'hFF);
        send_frame(8'h00, 0, 1'b0, 1'b0);
        send_frame(RST_FUNC_LIMIT - 1'b1, 2, 1'b0, 1'b1);
        send_frame(8'h12, 2, 1'b1, 1'b0);
        send_header();
        send_byte(RST_FUNC_LIMIT);
        send_header();
        send_byte(8'h01);
        send_byte(BYTE_W'(RST_MAX_PAYLOAD) + 1'b1);
        send_byte(tracker.sync_a);
        send_byte(tracker.sync_a);
        send_byte(tracker.sync_b);
        send_frame(8'h05, 1, 1'b0, 1'b0);
        settle();

        // Equal syncs of zero, widest limits, longest payload with no idling
        write_reg(REG_SYNC_FIRST, 8'h00);
        write_reg(REG_SYNC_SECOND, 8'h00);
        write_reg(REG_FUNC_LIMIT, 8'hFF);
        write_reg(REG_MAX_PAYLOAD, 8'hFF);
        write_reg(REG_UNUSED_LO, 8'h00);
        write_reg(REG_UNUSED_HI, 8'hFF);
        steady = 1'b1;
        send_frame(8'hFE, 63, 1'b0, 1'b1);
        send_frame(8'hFF, 0, 1'b0, 1'b0);
        send_frame(8'h00, 1, 1'b1, 1'b0);
        settle();
        steady = 1'b0;

        // Tightest limits: no code passes, then only code zero with no payload
        write_reg(REG_SYNC_FIRST, 8'hFF);
        write_reg(REG_SYNC_SECOND, 8'hFF);
        write_reg(REG_FUNC_LIMIT, 8'h00);
        write_reg(REG_MAX_PAYLOAD, 8'h00);
        send_frame(8'h00, 0, 1'b0, 1'b0);
        settle();
        write_reg(REG_FUNC_LIMIT, 8'h01);
        send_header();
        send_byte(8'h00);
        send_byte(8'h01);
        send_frame(8'h00, 0, 1'b0, 1'b0);
        send_frame(8'h00, 0, 1'b1, 1'b0);
        settle();

        // Random phases, each under its own register setting
        for (int ph = 0; ph < 3; ph++) begin
            if (ph == 0) begin
                write_reg(REG_SYNC_FIRST, RST_SYNC_FIRST);
                write_reg(REG_SYNC_SECOND, RST_SYNC_SECOND);
                write_reg(REG_FUNC_LIMIT, RST_FUNC_LIMIT);
                write_reg(REG_MAX_PAYLOAD, BYTE_W'(RST_MAX_PAYLOAD));
            end else begin
                write_reg(REG_SYNC_FIRST, BYTE_W'($urandom));
                write_reg(REG_SYNC_SECOND, BYTE_W'($urandom));
                write_reg(REG_FUNC_LIMIT, BYTE_W'($urandom_range(1, 255)));
                write_reg(REG_MAX_PAYLOAD, (ph == 2) ? BYTE_W'($urandom_range(8, 63))
                                                     : BYTE_W'($urandom_range(0, 63)));
            end
            steady = (ph == 1);
            start  = bytes_sent;
            // Hold the result side while a frame and more traffic arrive
            if (ph == 2) begin
                hold_request = 400;
                send_frame(BYTE_W'($urandom_range(0, tracker.code_limit - 1)), 6,
                           1'b0, 1'b0);
                send_random_item();
            end
            while (bytes_sent - start < PHASE_ITEMS) send_random_item();
            settle();
        end
        steady = 1'b0;

        if (tracker.pending() != 0)
            tracker.report_mismatch($sformatf("%0d expected results never arrived",
                                              tracker.pending()));
        if (tracker.mismatches == 0) begin
            $display("sum_checked_frame_receiver_top regression: pass");
        end else begin
            $display("sum_checked_frame_receiver_top regression: fail");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #5_000_000;
        $display("sum_checked_frame_receiver_top regression: fail");
        $finish;
    end

endmodule
